FILE: hw/rtl/hktlp_pkg.sv
// Package for the hashed key table: widths, status codes, command codes and the crypt table.
// The crypt table is built at elaboration by the linear congruential rule.
// No dependencies.
`timescale 1ns / 1ps
package hktlp_pkg;
  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int SIZE_W = 11;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1021;
  localparam logic [31:0] SEED_ONE_INIT = 32'h7FED7FED;
  localparam logic [31:0] SEED_TWO_INIT = 32'hEEEEEEEE;

  localparam logic [1:0] CMD_GET = 2'd0;
  localparam logic [1:0] CMD_SET = 2'd1;
  localparam logic [1:0] CMD_DEL = 2'd2;

  localparam logic [1:0] ST_HIT = 2'd0;
  localparam logic [1:0] ST_INSERTED = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef logic [31:0] rom_t [768];

  function automatic rom_t build_rom();
    rom_t r;
    logic [31:0] s;
    logic [31:0] hi;
    s = 32'h00100001;
    for (int row = 0; row < 256; row++) begin
      for (int k = 0; k < 5; k++) begin
        s = (s * 32'd125 + 32'd3) % 32'h2AAAAB;
        hi = (s & 32'hFFFF) << 16;
        s = (s * 32'd125 + 32'd3) % 32'h2AAAAB;
        if (k < 3) r[row + k * 256] = hi | (s & 32'hFFFF);
      end
    end
    return r;
  endfunction

  localparam rom_t CRYPT_ROM = build_rom();

  typedef struct packed {
    logic [31:0] s1;
    logic [31:0] s2;
  } seed_t;
endpackage

FILE: hw/rtl/hktlp_if.sv
// Valid/ready stream interfaces for the key table input and result channels.
// Depends on nothing.
`timescale 1ns / 1ps
interface hktlp_in_if;
  logic valid;
  logic ready;
  logic [1:0] cmd;
  logic [7:0] key_byte;
  logic key_last;
  logic [31:0] value;
  logic [15:0] value_len;
  modport source(output valid, cmd, key_byte, key_last, value, value_len, input ready);
  modport sink(input valid, cmd, key_byte, key_last, value, value_len, output ready);
endinterface

interface hktlp_out_if;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic [31:0] found_value;
  logic [15:0] found_len;
  modport source(output valid, status, found_value, found_len, input ready);
  modport sink(input valid, status, found_value, found_len, output ready);
endinterface

FILE: hw/rtl/hktlp_hash.sv
// One crypt-table hash lane: folds one case-folded key byte into a running seed pair.
// Depends on hktlp_pkg.
`timescale 1ns / 1ps
module hktlp_hash #(
  parameter int HTYPE = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic               restart,
  input  logic [7:0]         ch,
  output hktlp_pkg::seed_t   seed
);
  logic [31:0] s1_new;
  logic [31:0] s2_new;

  always_comb begin
    s1_new = hktlp_pkg::CRYPT_ROM[HTYPE * 256 + int'(ch)] ^ (seed.s1 + seed.s2);
    s2_new = {24'd0, ch} + s1_new + seed.s2 + {seed.s2[26:0], 5'd0} + 32'd3;
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      seed.s1 <= hktlp_pkg::SEED_ONE_INIT;
      seed.s2 <= hktlp_pkg::SEED_TWO_INIT;
    end else if (step) begin
      seed.s1 <= s1_new;
      seed.s2 <= s2_new;
    end
  end
endmodule

FILE: hw/rtl/hashed_key_table_linear_probe.sv
// Top level of the hashed key table with linear probing.
// Depends on hktlp_pkg, the hktlp stream interfaces and hktlp_hash.
//
// Key bytes arrive on in_ch, one per transfer; the byte with key_last set
// carries the command and, for a set, the value and length. A byte that is
// not last only steps the running hashes and gives no result. A last byte
// takes the start slot as the offset hash modulo the table size (clamped to
// 1 .. TABLE_DEPTH), found by restoring subtraction one quotient bit per
// cycle, then probes the slot memory (S_READ twice and S_CMP for the first
// slot, S_READ and S_CMP for each further slot) until a match, an empty slot
// or a wrap. In S_CMP it writes the slot for a set that matches or finds an
// empty slot and for a delete that matches, then presents one result on
// out_ch. The result waits in an output register while the receiver stalls;
// the next key byte is taken only after that result is transferred.
// Reset loads the running hashes with their seeds and the table size register
// with 1021, then runs a clearing pass over all TABLE_DEPTH slots during
// which no key byte is taken. cfg_we writes table_size at any edge.
module hashed_key_table_linear_probe #(
  parameter int TABLE_DEPTH = hktlp_pkg::TABLE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [hktlp_pkg::SIZE_W-1:0] cfg_wdata,
  hktlp_in_if.sink                    in_ch,
  hktlp_out_if.source                 out_ch
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int PW = AW + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MOD   = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;
  localparam logic [2:0] S_CLEAR = 3'd5;

  logic [2:0] state;
  logic [hktlp_pkg::SIZE_W-1:0] table_size;
  logic [PW-1:0] n;
  logic [7:0] ch;
  logic in_fire;
  hktlp_pkg::seed_t seed0, seed1, seed2;

  logic [31:0] ca, cb, dividend;
  logic [PW-1:0] rem;
  logic [5:0] bit_cnt;
  logic [AW-1:0] pos, start;
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] mem_addr;
  logic [1:0] cmd;
  logic [31:0] val;
  logic [15:0] vlen;

  logic [96:0] mem [TABLE_DEPTH];
  logic [111:0] mem_len;
  logic [96:0] rd;
  logic [15:0] len_mem [TABLE_DEPTH];
  logic [15:0] rd_len;
  logic rd_used;

  logic [1:0] status;
  logic [31:0] fval;
  logic [15:0] flen;

  logic [PW:0] rem_sh;
  logic [AW-1:0] pos_inc;
  logic match;
  logic wr_en;
  logic [96:0] wr_data;
  logic [15:0] wr_len;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IDLE);
  assign ch = (in_ch.key_byte >= 8'h61 && in_ch.key_byte <= 8'h7A) ?
              in_ch.key_byte - 8'h20 : in_ch.key_byte;
  assign mem_len = {rd[95:0], rd_len};
  assign rd_used = rd[96];
  assign mem_addr = (state == S_CLEAR) ? clr_addr : pos;

  always_comb begin
    if (table_size == '0) n = PW'(1);
    else if (32'(table_size) > TABLE_DEPTH) n = PW'(TABLE_DEPTH);
    else n = PW'(table_size);
  end

  hktlp_hash #(.HTYPE(0)) u_h0 (.clk, .rst, .step(in_fire), .restart(in_fire && in_ch.key_last),
                               .ch, .seed(seed0));
  hktlp_hash #(.HTYPE(1)) u_h1 (.clk, .rst, .step(in_fire), .restart(in_fire && in_ch.key_last),
                               .ch, .seed(seed1));
  hktlp_hash #(.HTYPE(2)) u_h2 (.clk, .rst, .step(in_fire), .restart(in_fire && in_ch.key_last),
                               .ch, .seed(seed2));

  // Final-byte s1 values are computed the same way here to capture the last fold.
  logic [31:0] f0, f1, f2;
  always_comb begin
    f0 = hktlp_pkg::CRYPT_ROM[int'(ch)] ^ (seed0.s1 + seed0.s2);
    f1 = hktlp_pkg::CRYPT_ROM[256 + int'(ch)] ^ (seed1.s1 + seed1.s2);
    f2 = hktlp_pkg::CRYPT_ROM[512 + int'(ch)] ^ (seed2.s1 + seed2.s2);
  end

  always_comb begin
    rem_sh = {rem, dividend[31]};
    pos_inc = (32'(pos) + 1 == 32'(n)) ? '0 : pos + AW'(1);
    match = rd_used && rd[95:64] == ca && rd[63:32] == cb;
  end

  always_ff @(posedge clk) begin
    if (rst) table_size <= hktlp_pkg::SIZE_RESET;
    else if (cfg_we) table_size <= cfg_wdata;
  end

  always_ff @(posedge clk) begin
    rd <= mem[mem_addr];
    rd_len <= len_mem[mem_addr];
    if (wr_en) begin
      mem[mem_addr] <= wr_data;
      len_mem[mem_addr] <= wr_len;
    end
  end

  always_comb begin
    wr_en = 1'b0;
    wr_data = {1'b1, ca, cb, val};
    wr_len = vlen;
    if (state == S_CLEAR) begin
      wr_en = 1'b1;
      wr_data = '0;
      wr_len = '0;
    end else if (state == S_CMP && cmd == hktlp_pkg::CMD_SET) begin
      if (match) begin
        wr_en = 1'b1;
        wr_data = {rd[96:32], val};
      end else if (!rd_used) begin
        wr_en = 1'b1;
      end
    end else if (state == S_CMP && cmd == hktlp_pkg::CMD_DEL && match) begin
      wr_en = 1'b1;
      wr_data = {1'b0, rd[95:0]};
      wr_len = rd_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (32'(clr_addr) == TABLE_DEPTH - 1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_fire && in_ch.key_last) begin
            ca <= f1;
            cb <= f2;
            dividend <= f0;
            rem <= '0;
            bit_cnt <= '0;
            cmd <= in_ch.cmd;
            val <= in_ch.value;
            vlen <= in_ch.value_len;
            state <= S_MOD;
          end
        end
        S_MOD: begin
          dividend <= {dividend[30:0], 1'b0};
          if (rem_sh >= {1'b0, n}) rem <= PW'(rem_sh - {1'b0, n});
          else rem <= rem_sh[PW-1:0];
          bit_cnt <= bit_cnt + 6'd1;
          if (bit_cnt == 6'd31) state <= S_READ;
        end
        S_READ: begin
          if (bit_cnt == 6'd32) begin
            pos <= rem[AW-1:0];
            start <= rem[AW-1:0];
            bit_cnt <= '0;
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          fval <= '0;
          flen <= '0;
          if (match) begin
            status <= hktlp_pkg::ST_HIT;
            if (cmd != hktlp_pkg::CMD_SET) begin
              fval <= mem_len[47:16];
              flen <= mem_len[15:0];
            end
            state <= S_OUT;
          end else if (!rd_used) begin
            if (cmd == hktlp_pkg::CMD_SET) status <= hktlp_pkg::ST_INSERTED;
            else status <= hktlp_pkg::ST_MISSING;
            state <= S_OUT;
          end else if (pos_inc == start) begin
            status <= (cmd == hktlp_pkg::CMD_SET) ? hktlp_pkg::ST_FULL : hktlp_pkg::ST_MISSING;
            state <= S_OUT;
          end else begin
            pos <= pos_inc;
            state <= S_READ;
          end
        end
        S_OUT: begin
          if (!out_ch.valid) out_ch.valid <= 1'b1;
          else if (out_ch.ready) begin
            out_ch.valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.status = status;
  assign out_ch.found_value = fval;
  assign out_ch.found_len = flen;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ch.ready) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.status)))
    else $error("result dropped while stalled");
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> (32'(pos) < 32'(n))) else $error("probe beyond table size");
endmodule
